[design/mrp_pkg.sv]
// shared types and constants of the mips relocation patcher
package mrp_pkg;

  localparam int PendingDepthDefault = 16;

  // elf mips relocation types
  localparam logic [7:0] RELOC_NONE   = 8'd0;
  localparam logic [7:0] RELOC_WORD32 = 8'd2;
  localparam logic [7:0] RELOC_JUMP26 = 8'd4;
  localparam logic [7:0] RELOC_HI16   = 8'd5;
  localparam logic [7:0] RELOC_LO16   = 8'd6;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_UNDEF   = 2'd1;
  localparam logic [1:0] STAT_FAIL    = 2'd2;
  localparam logic [1:0] STAT_UNKNOWN = 2'd3;

  // which result the datapath puts on the output
  typedef enum logic [1:0] {
    SEL_SIMPLE,
    SEL_PEND,
    SEL_MISMATCH
  } sel_t;

  typedef struct packed {
    logic latch;
    logic commit;
    logic emit;
    logic pop;
    sel_t sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lo_pending;
    logic cnt_one;
    logic sym_match;
  } ctrl_stat_t;

endpackage

[design/mrp_ctrl.sv]
// controller state machine of the mips relocation patcher
module mrp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mrp_pkg::ctrl_stat_t stat,
  output mrp_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EXEC    = 2'd1;
  localparam logic [1:0] S_LO_EMIT = 2'd2;
  localparam logic [1:0] S_LO_OWN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.latch  = 1'b0;
    cmd.commit = 1'b0;
    cmd.emit   = 1'b0;
    cmd.pop    = 1'b0;
    cmd.sel    = mrp_pkg::SEL_SIMPLE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.lo_pending) begin
          state_nxt = S_LO_EMIT;
        end else begin
          cmd.emit   = 1'b1;
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_LO_EMIT: begin
        cmd.emit = 1'b1;
        cmd.pop  = 1'b1;
        if (!stat.sym_match) begin
          cmd.sel   = mrp_pkg::SEL_MISMATCH;
          state_nxt = S_IDLE;
        end else begin
          cmd.sel = mrp_pkg::SEL_PEND;
          if (stat.cnt_one) begin
            state_nxt = S_LO_OWN;
          end
        end
      end
      S_LO_OWN: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_EXEC))
    else $error("accepted request did not enter exec");
  a_own_after_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LO_OWN) |-> ($past(state_r) == S_LO_EMIT))
    else $error("lo16 own patch without pending loop");
  a_mismatch_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.sel == mrp_pkg::SEL_MISMATCH) |=> !busy)
    else $error("symbol mismatch did not end the request");
`endif

endmodule

[design/mrp_datapath.sv]
// datapath of the mips relocation patcher: input latch, pending stack, patch math
module mrp_datapath #(
  parameter int PENDING_DEPTH = mrp_pkg::PendingDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mrp_pkg::ctrl_cmd_t  cmd,
  output mrp_pkg::ctrl_stat_t stat,
  input  logic [7:0]          in_command,
  input  logic [31:0]         in_place_address,
  input  logic [31:0]         in_word_in,
  input  logic [31:0]         in_symbol_value,
  input  logic                in_symbol_defined,
  output logic [31:0]         out_patch_address,
  output logic [31:0]         out_patch_word,
  output logic                out_write_enable,
  output logic [1:0]          out_status,
  output logic                out_last,
  output logic                out_strobe
);

  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  // latched request
  logic [7:0]  command_r;
  logic [31:0] place_r;
  logic [31:0] word_r;
  logic [31:0] sym_r;
  logic        defined_r;
  logic [31:0] lo_sum_r;

  // pending stack
  logic [95:0]      pend_mem [PENDING_DEPTH];
  logic [95:0]      rd_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] rd_cnt;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             push;
  logic             full;

  // output registers
  logic [31:0] addr_r,  addr_nxt;
  logic [31:0] pword_r, pword_nxt;
  logic        we_r,    we_nxt;
  logic [1:0]  stat_r,  stat_nxt;
  logic        last_r,  last_nxt;
  logic        strobe_r;

  // single-result computation
  logic [31:0] s_word;
  logic        s_we;
  logic [1:0]  s_stat;
  logic [31:0] jtarget;
  logic [31:0] place4;
  logic [31:0] hi_v;
  logic [15:0] hi_half;
  logic [31:0] rd_place;
  logic [31:0] rd_word;
  logic [31:0] rd_sym;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      command_r <= in_command;
      place_r   <= in_place_address;
      word_r    <= in_word_in;
      sym_r     <= in_symbol_value;
      defined_r <= in_symbol_defined;
      lo_sum_r  <= in_symbol_value + {{16{in_word_in[15]}}, in_word_in[15:0]};
    end
  end

  assign full   = (count_r >= CNT_W'(PENDING_DEPTH));
  assign push   = cmd.commit && (command_r == mrp_pkg::RELOC_HI16) && defined_r && !full;
  assign wr_idx = count_r[IDX_W-1:0];

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // read the entry that will be on top after this edge
  assign rd_cnt = count_nxt - CNT_W'(1);
  assign rd_idx = rd_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (push) begin
      pend_mem[wr_idx] <= {place_r, word_r, sym_r};
    end
    rd_r <= pend_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign rd_place = rd_r[95:64];
  assign rd_word  = rd_r[63:32];
  assign rd_sym   = rd_r[31:0];

  always_comb begin
    stat.lo_pending = (command_r == mrp_pkg::RELOC_LO16) && defined_r && (count_r != '0);
    stat.cnt_one    = (count_r == CNT_W'(1));
    stat.sym_match  = (rd_sym == sym_r);
  end

  assign jtarget = sym_r + {{4{word_r[25]}}, word_r[25:0], 2'b00};
  assign place4  = place_r + 32'd4;

  always_comb begin
    s_word = word_r;
    s_we   = 1'b0;
    s_stat = mrp_pkg::STAT_OK;
    priority if (command_r == mrp_pkg::RELOC_NONE) begin
      s_stat = mrp_pkg::STAT_OK;
    end else if (command_r != mrp_pkg::RELOC_WORD32 && command_r != mrp_pkg::RELOC_JUMP26 &&
                 command_r != mrp_pkg::RELOC_HI16 && command_r != mrp_pkg::RELOC_LO16) begin
      s_stat = mrp_pkg::STAT_UNKNOWN;
    end else if (!defined_r) begin
      s_stat = mrp_pkg::STAT_UNDEF;
    end else if (command_r == mrp_pkg::RELOC_WORD32) begin
      s_word = word_r + sym_r;
      s_we   = 1'b1;
    end else if (command_r == mrp_pkg::RELOC_JUMP26) begin
      if (sym_r[1:0] != 2'b00 || jtarget[31:28] != place4[31:28]) begin
        s_stat = mrp_pkg::STAT_FAIL;
      end else begin
        s_word = {word_r[31:26], jtarget[27:2]};
        s_we   = 1'b1;
      end
    end else if (command_r == mrp_pkg::RELOC_HI16) begin
      if (full) begin
        s_stat = mrp_pkg::STAT_FAIL;
      end
    end else begin
      s_word = {word_r[31:16], lo_sum_r[15:0]};
      s_we   = 1'b1;
    end
  end

  // hi16 patch: high half of (hi << 16) + lo + sym, rounded on bit 15
  assign hi_v    = {rd_word[15:0], 16'h0000} + lo_sum_r;
  assign hi_half = hi_v[31:16] + {15'd0, hi_v[15]};

  always_comb begin
    addr_nxt  = place_r;
    pword_nxt = s_word;
    we_nxt    = s_we;
    stat_nxt  = s_stat;
    last_nxt  = 1'b1;
    unique case (cmd.sel)
      mrp_pkg::SEL_SIMPLE: begin
        addr_nxt = place_r;
      end
      mrp_pkg::SEL_PEND: begin
        addr_nxt  = rd_place;
        pword_nxt = {rd_word[31:16], hi_half};
        we_nxt    = 1'b1;
        stat_nxt  = mrp_pkg::STAT_OK;
        last_nxt  = 1'b0;
      end
      mrp_pkg::SEL_MISMATCH: begin
        pword_nxt = word_r;
        we_nxt    = 1'b0;
        stat_nxt  = mrp_pkg::STAT_FAIL;
      end
      default: begin
        we_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      addr_r  <= addr_nxt;
      pword_r <= pword_nxt;
      we_r    <= we_nxt;
      stat_r  <= stat_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
    end
  end

  assign out_patch_address = addr_r;
  assign out_patch_word    = pword_r;
  assign out_write_enable  = we_r;
  assign out_status        = stat_r;
  assign out_last          = last_r;
  assign out_strobe        = strobe_r;

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop from empty pending stack");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(PENDING_DEPTH))
    else $error("pending count above depth");
  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not decrement pending count");
`endif

endmodule

[design/mips_relocation_patcher_top.sv]
// top level of the mips relocation patcher: controller plus datapath
//
// channel   direction  ports                                         handshake
// request   in         in_command, in_place_address, in_word_in,     start && !busy
//                      in_symbol_value, in_symbol_defined
// result    out        out_patch_address, out_patch_word,            out_strobe, one cycle
//                      out_write_enable, out_status, out_last
//
// every request except a lo16 with pending hi16 entries is handled in order:
//   latch, then compute; the result strobes in the following cycle
// a lo16 with n pending entries runs: latch, check, the popped entries one by one
//   (single read port of the pending stack), then its own patch;
//   a symbol mismatch ends it right after the offending entry
// reset (rst_n low, synchronous) empties the pending stack; no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle
module mips_relocation_patcher_top #(
  parameter int PENDING_DEPTH = mrp_pkg::PendingDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_command,
  input  logic [31:0] in_place_address,
  input  logic [31:0] in_word_in,
  input  logic [31:0] in_symbol_value,
  input  logic        in_symbol_defined,
  // result channel
  output logic        out_strobe,
  output logic [31:0] out_patch_address,
  output logic [31:0] out_patch_word,
  output logic        out_write_enable,
  output logic [1:0]  out_status,
  output logic        out_last
);

  // command and status between controller and datapath
  mrp_pkg::ctrl_cmd_t  cmd;
  mrp_pkg::ctrl_stat_t stat;

  // sequencer: latch, compute, then walk pending hi16 entries for a lo16
  mrp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // pending stack, patch arithmetic and output registers
  mrp_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_command),
    .in_place_address  (in_place_address),
    .in_word_in        (in_word_in),
    .in_symbol_value   (in_symbol_value),
    .in_symbol_defined (in_symbol_defined),
    .out_patch_address (out_patch_address),
    .out_patch_word    (out_patch_word),
    .out_write_enable  (out_write_enable),
    .out_status        (out_status),
    .out_last          (out_last),
    .out_strobe        (out_strobe)
  );

endmodule

[verif/mips_relocation_patcher_top_tb.sv]
// self-checking testbench of the mips relocation patcher top level
module mips_relocation_patcher_top_tb;

  // pending stack depth of the instance; the patch predictor keeps a stack this deep
  localparam int PendDepth = mrp_pkg::PendingDepthDefault;
  // hard stop, far beyond the slowest correct run:
  // ~420 requests, each with its pending pops, latch/compute and sender gaps
  localparam int CycleLimit = 200000;
  // trailing wait after the last patch: a full pending unwind plus the pipeline
  localparam int DrainCycles = PendDepth + 8;
  localparam logic [7:0] RelocTypeMax = 8'hff;

  // one patch as it leaves the block
  typedef struct {
    logic [31:0] addr;
    logic [31:0] word;
    logic        we;
    logic [1:0]  status;
    logic        last;
  } patch_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_command = mrp_pkg::RELOC_NONE;
  logic [31:0] in_place_address = '0;
  logic [31:0] in_word_in = '0;
  logic [31:0] in_symbol_value = '0;
  logic        in_symbol_defined = 1'b0;
  logic        out_strobe;
  logic [31:0] out_patch_address;
  logic [31:0] out_patch_word;
  logic        out_write_enable;
  logic [1:0]  out_status;
  logic        out_last;

  // shadow of the block's hi16 pending stack
  int unsigned held_count = 0;
  logic [31:0] held_place [PendDepth];
  logic [31:0] held_word [PendDepth];
  logic [31:0] held_symbol [PendDepth];

  // patches predicted but not yet seen on the result port, oldest first
  patch_t      due_patches [$];

  int unsigned mismatch_count = 0;
  int unsigned n_requests = 0;
  int unsigned cycle_count = 0;
  // chance in percent that the sender idles in a given cycle
  int unsigned idle_pct = 0;

  mips_relocation_patcher_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_place_address  (in_place_address),
    .in_word_in        (in_word_in),
    .in_symbol_value   (in_symbol_value),
    .in_symbol_defined (in_symbol_defined),
    .out_strobe        (out_strobe),
    .out_patch_address (out_patch_address),
    .out_patch_word    (out_patch_word),
    .out_write_enable  (out_write_enable),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost patch ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // patch predictor
  // ---------------------------------------------------------------------------

  function automatic void push_patch(logic [31:0] addr, logic [31:0] word, logic we,
                                     logic [1:0] status, logic last);
    patch_t p;
    p.addr = addr;
    p.word = word;
    p.we = we;
    p.status = status;
    p.last = last;
    due_patches.push_back(p);
  endfunction

  // works out every patch that one accepted relocation request causes
  function automatic void relocate(logic [7:0] cmd, logic [31:0] place, logic [31:0] word,
                                   logic [31:0] sym, logic defined);
    logic [31:0] target;
    logic [31:0] place4;
    logic [31:0] addlo;
    logic [31:0] hw;
    logic [31:0] v;
    logic [15:0] hi_half;
    int unsigned i;
    // type checks come before the symbol check; none never looks at the symbol
    if (cmd == mrp_pkg::RELOC_NONE) begin
      push_patch(place, word, 1'b0, mrp_pkg::STAT_OK, 1'b1);
      return;
    end
    if (cmd != mrp_pkg::RELOC_WORD32 && cmd != mrp_pkg::RELOC_JUMP26 &&
        cmd != mrp_pkg::RELOC_HI16 && cmd != mrp_pkg::RELOC_LO16) begin
      push_patch(place, word, 1'b0, mrp_pkg::STAT_UNKNOWN, 1'b1);
      return;
    end
    if (!defined) begin
      push_patch(place, word, 1'b0, mrp_pkg::STAT_UNDEF, 1'b1);
      return;
    end
    case (cmd)
      mrp_pkg::RELOC_WORD32: begin
        push_patch(place, word + sym, 1'b1, mrp_pkg::STAT_OK, 1'b1);
      end
      mrp_pkg::RELOC_JUMP26: begin
        // target = symbol + sign-extended 26-bit field in words
        target = sym + ({{6{word[25]}}, word[25:0]} << 2);
        place4 = place + 32'd4;
        if (sym[1:0] != 2'b00 || target[31:28] != place4[31:28]) begin
          push_patch(place, word, 1'b0, mrp_pkg::STAT_FAIL, 1'b1);
        end else begin
          push_patch(place, {word[31:26], target[27:2]}, 1'b1, mrp_pkg::STAT_OK, 1'b1);
        end
      end
      mrp_pkg::RELOC_HI16: begin
        if (held_count >= PendDepth) begin
          push_patch(place, word, 1'b0, mrp_pkg::STAT_FAIL, 1'b1);
        end else begin
          held_place[held_count] = place;
          held_word[held_count] = word;
          held_symbol[held_count] = sym;
          held_count++;
          push_patch(place, word, 1'b0, mrp_pkg::STAT_OK, 1'b1);
        end
      end
      default: begin
        // lo16: unwind the pending hi16 entries newest first
        addlo = {{16{word[15]}}, word[15:0]};
        while (held_count > 0) begin
          held_count--;
          i = held_count;
          if (held_symbol[i] != sym) begin
            // the offending entry is gone, older ones stay pending
            push_patch(place, word, 1'b0, mrp_pkg::STAT_FAIL, 1'b1);
            return;
          end
          hw = held_word[i];
          v = {hw[15:0], 16'h0000} + addlo + sym;
          // round the high half up when the low half reads as negative
          hi_half = v[15] ? v[31:16] + 16'd1 : v[31:16];
          push_patch(held_place[i], {hw[31:16], hi_half}, 1'b1, mrp_pkg::STAT_OK, 1'b0);
        end
        v = sym + addlo;
        push_patch(place, {word[31:16], v[15:0]}, 1'b1, mrp_pkg::STAT_OK, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking and request monitoring, both sampled at the rising edge
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    $display("%0t: %s expected %h got %h", $time, field, want, got);
  endfunction

  function automatic void check_patch();
    patch_t want;
    if (due_patches.size() == 0) begin
      mismatch_count++;
      $display("%0t: patch with none predicted, address %h word %h",
               $time, out_patch_address, out_patch_word);
      return;
    end
    want = due_patches.pop_front();
    if (out_patch_address !== want.addr)
      note_mismatch("patch_address", want.addr, out_patch_address);
    if (out_patch_word !== want.word)
      note_mismatch("patch_word", want.word, out_patch_word);
    if (out_write_enable !== want.we)
      note_mismatch("write_enable", 32'(want.we), 32'(out_write_enable));
    if (out_status !== want.status)
      note_mismatch("status", 32'(want.status), 32'(out_status));
    if (out_last !== want.last)
      note_mismatch("last", 32'(want.last), 32'(out_last));
  endfunction

  // the patch is checked before the request of the same edge is predicted:
  // a request never produces a patch at the edge that accepts it
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        check_patch();
      if (start && !busy)
        relocate(in_command, in_place_address, in_word_in, in_symbol_value,
                 in_symbol_defined);
    end
  end

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // random idle cycles after a request; start only drops when a gap is taken,
  // so back-to-back requests keep it high without a second assignment
  task automatic sender_pause();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_reloc(logic [7:0] cmd, logic [31:0] place, logic [31:0] word,
                            logic [31:0] sym, logic defined);
    start <= 1'b1;
    in_command <= cmd;
    in_place_address <= place;
    in_word_in <= word;
    in_symbol_value <= sym;
    in_symbol_defined <= defined;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_requests++;
    sender_pause();
  endtask

  function automatic logic [7:0] rand_unknown_type();
    logic [7:0] t;
    do t = 8'($urandom_range(255));
    while (t == mrp_pkg::RELOC_NONE || t == mrp_pkg::RELOC_WORD32 ||
           t == mrp_pkg::RELOC_JUMP26 || t == mrp_pkg::RELOC_HI16 ||
           t == mrp_pkg::RELOC_LO16);
    return t;
  endfunction

  // one relocation that does not touch the pending stack, or one that is rejected
  task automatic send_noise();
    logic [31:0] place;
    logic [31:0] place4;
    logic [31:0] sym;
    place = $urandom;
    case ($urandom_range(5))
      0: send_reloc(mrp_pkg::RELOC_NONE, place, $urandom, $urandom, 1'($urandom));
      1: send_reloc(rand_unknown_type(), place, $urandom, $urandom, 1'($urandom));
      2: send_reloc(mrp_pkg::RELOC_WORD32, place, $urandom, $urandom, 1'b1);
      3, 4: begin
        // jump target mostly in the region of place + 4, sometimes misaligned
        place4 = place + 32'd4;
        sym = {place4[31:28], 28'($urandom)};
        if ($urandom_range(7) != 0)
          sym[1:0] = 2'b00;
        send_reloc(mrp_pkg::RELOC_JUMP26, place, $urandom, sym, 1'b1);
      end
      default: begin
        case ($urandom_range(3))
          0: send_reloc(mrp_pkg::RELOC_WORD32, place, $urandom, $urandom, 1'b0);
          1: send_reloc(mrp_pkg::RELOC_JUMP26, place, $urandom, $urandom, 1'b0);
          2: send_reloc(mrp_pkg::RELOC_HI16, place, $urandom, $urandom, 1'b0);
          default: send_reloc(mrp_pkg::RELOC_LO16, place, $urandom, $urandom, 1'b0);
        endcase
      end
    endcase
  endtask

  // a run of hi16 requests closed by a lo16, as a linker sees them
  task automatic send_hi_lo_chain();
    logic [31:0] sym;
    int unsigned n_hi;
    sym = $urandom;
    // a few chains run past the stack depth to hit the full stack
    n_hi = ($urandom_range(9) == 0) ? $urandom_range(PendDepth - 2, PendDepth + 2)
                                    : $urandom_range(3);
    repeat (n_hi) begin
      if ($urandom_range(9) == 0)
        send_noise();
      // now and then a hi16 of another symbol breaks the pairing
      send_reloc(mrp_pkg::RELOC_HI16, $urandom, $urandom,
                 ($urandom_range(14) == 0) ? $urandom : sym,
                 $urandom_range(29) != 0);
    end
    send_reloc(mrp_pkg::RELOC_LO16, $urandom, $urandom,
               ($urandom_range(19) == 0) ? $urandom : sym,
               $urandom_range(24) != 0);
  endtask

  // waits out every predicted patch, then a full unwind's worth of cycles
  task automatic drain();
    start <= 1'b0;
    while (due_patches.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // none and unknown types, with the field extremes riding along
  task automatic test_none_and_unknown();
    send_reloc(mrp_pkg::RELOC_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_reloc(mrp_pkg::RELOC_WORD32 + 8'd1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
               1'b1);
    send_reloc(RelocTypeMax, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 1'b0);
  endtask

  task automatic test_word32();
    // sum wraps past the top of the address space
    send_reloc(mrp_pkg::RELOC_WORD32, 32'h0000_1000, 32'hffff_ffff, 32'h0000_0001, 1'b1);
    send_reloc(mrp_pkg::RELOC_WORD32, 32'h0000_1004, 32'h1234_5678, 32'h8765_4321, 1'b0);
  endtask

  task automatic test_jump26();
    // forward and backward jumps inside the region
    send_reloc(mrp_pkg::RELOC_JUMP26, 32'h0040_0000, 32'h0c00_0010, 32'h0040_1000, 1'b1);
    send_reloc(mrp_pkg::RELOC_JUMP26, 32'h0040_0004, 32'h0bff_fff0, 32'h0040_1000, 1'b1);
    // symbol not word aligned
    send_reloc(mrp_pkg::RELOC_JUMP26, 32'h0040_0008, 32'h0c00_0000, 32'h0040_1002, 1'b1);
    // delay slot lands in the next region, target stays in this one
    send_reloc(mrp_pkg::RELOC_JUMP26, 32'h0fff_fffc, 32'h0800_0000, 32'h0fff_0000, 1'b1);
    // place + 4 wraps to zero
    send_reloc(mrp_pkg::RELOC_JUMP26, 32'hffff_fffc, 32'h0800_0000, 32'h0000_0100, 1'b1);
  endtask

  task automatic test_hi_lo();
    // lo16 alone only patches itself
    send_reloc(mrp_pkg::RELOC_LO16, 32'h0000_2000, 32'h2421_8000, 32'h1234_5678, 1'b1);
    // two hi16s resolved by one lo16, negative low half forces the carry
    send_reloc(mrp_pkg::RELOC_HI16, 32'h0000_3000, 32'h3c01_0000, 32'h1000_8000, 1'b1);
    send_reloc(mrp_pkg::RELOC_HI16, 32'h0000_3010, 32'h3c02_ffff, 32'h1000_8000, 1'b1);
    send_reloc(mrp_pkg::RELOC_LO16, 32'h0000_3020, 32'h2421_8000, 32'h1000_8000, 1'b1);
    // the oldest hi16 belongs to another symbol: two patches, then failure
    send_reloc(mrp_pkg::RELOC_HI16, 32'h0000_4000, 32'h3c03_0001, 32'hdead_0000, 1'b1);
    send_reloc(mrp_pkg::RELOC_HI16, 32'h0000_4010, 32'h3c04_0002, 32'hbeef_0000, 1'b1);
    send_reloc(mrp_pkg::RELOC_HI16, 32'h0000_4020, 32'h3c05_0003, 32'hbeef_0000, 1'b1);
    send_reloc(mrp_pkg::RELOC_LO16, 32'h0000_4030, 32'h2421_7fff, 32'hbeef_0000, 1'b1);
    // undefined lo16 leaves the stack alone; the next lo16 finds no pending entry
    send_reloc(mrp_pkg::RELOC_LO16, 32'h0000_4040, 32'h2421_0004, 32'hdead_0000, 1'b0);
    send_reloc(mrp_pkg::RELOC_HI16, 32'h0000_4050, 32'h3c06_0000, 32'hdead_0000, 1'b0);
    send_reloc(mrp_pkg::RELOC_LO16, 32'h0000_4060, 32'h2421_0004, 32'hdead_0000, 1'b1);
  endtask

  // fill the stack, overflow it by one, then resolve all entries in one go
  task automatic test_full_stack();
    logic [31:0] sym;
    sym = $urandom;
    repeat (PendDepth + 1)
      send_reloc(mrp_pkg::RELOC_HI16, $urandom, $urandom, sym, 1'b1);
    send_reloc(mrp_pkg::RELOC_LO16, $urandom, $urandom, sym, 1'b1);
  endtask

  // mostly hi16/lo16 chains with random content, the rest loose relocations
  task automatic test_random_mix(int unsigned pct, int unsigned n_items);
    int unsigned goal;
    idle_pct = pct;
    goal = n_requests + n_items;
    test_full_stack();
    while (n_requests < goal) begin
      if ($urandom_range(3) == 0)
        send_noise();
      else
        send_hi_lo_chain();
    end
  endtask

  initial begin
    // synchronous reset held from time zero, released once
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 26;
    test_none_and_unknown();
    test_word32();
    test_jump26();
    test_hi_lo();

    // sender idles lightly, then heavily, then not at all
    test_random_mix(26, 130);
    test_random_mix(80, 130);
    test_random_mix(0, 130);
    drain();

    if (mismatch_count == 0 && due_patches.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
